>>> rtl/mbcq_pkg.sv
// ----------------------------------------------------------------------------
// mbcq_pkg
// shared types and constants of the mouse button click qualifier
// ----------------------------------------------------------------------------
package mbcq_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MAX_TICKS_W  = 16;
  localparam int DIST_LIMIT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_DCLICK_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_DIST = 2'd1;

  localparam logic [MAX_TICKS_W-1:0]  MAX_TICKS_RST  = 16'd30;
  localparam logic [DIST_LIMIT_W-1:0] DIST_LIMIT_RST = 11'd4;

  typedef struct packed {
    logic [MAX_TICKS_W-1:0]  max_ticks;
    logic [DIST_LIMIT_W-1:0] dist_limit;
  } cfg_t;

  typedef struct packed {
    logic left_was_down;
    logic right_was_down;
    logic left_pressed;
    logic right_pressed;
    logic left_released;
    logic right_released;
    logic left_double_click;
  } flags_t;

endpackage

>>> rtl/mbcq_cfg.sv
// ----------------------------------------------------------------------------
// mbcq_cfg
// configuration register file: double-click window and distance limit
// ----------------------------------------------------------------------------
module mbcq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbcq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbcq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mbcq_pkg::cfg_t                   cfg
);

  mbcq_pkg::cfg_t cfg_r;
  mbcq_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      if (cfg_index == mbcq_pkg::REG_DCLICK_MAX) begin
        cfg_nxt.max_ticks = cfg_data[mbcq_pkg::MAX_TICKS_W-1:0];
      end else if (cfg_index == mbcq_pkg::REG_CLICK_DIST) begin
        cfg_nxt.dist_limit = cfg_data[mbcq_pkg::DIST_LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_ticks  <= mbcq_pkg::MAX_TICKS_RST;
      cfg_r.dist_limit <= mbcq_pkg::DIST_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/mbcq_track.sv
// ----------------------------------------------------------------------------
// mbcq_track
// button history, press position and double-click timer with edge flags
// ----------------------------------------------------------------------------
module mbcq_track #(
  parameter int COORD_BITS = 10,
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [COORD_BITS-1:0] pointer_x,
  input  logic [COORD_BITS-1:0] pointer_y,
  input  logic                  left_level,
  input  logic                  right_level,
  input  mbcq_pkg::cfg_t        cfg,
  output mbcq_pkg::flags_t      flags
);

  localparam int DIST_W  = COORD_BITS + 1;
  localparam int DCMP_W  = (DIST_W > mbcq_pkg::DIST_LIMIT_W) ? DIST_W : mbcq_pkg::DIST_LIMIT_W;
  localparam int TCMP_W  = (TIMER_BITS > mbcq_pkg::MAX_TICKS_W) ? TIMER_BITS
                                                               : mbcq_pkg::MAX_TICKS_W;

  logic                  left_prev_r, left_prev_nxt;
  logic                  right_prev_r, right_prev_nxt;
  logic [COORD_BITS-1:0] press_x_r, press_x_nxt;
  logic [COORD_BITS-1:0] press_y_r, press_y_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [DIST_W-1:0]     dist_sum;
  logic                  too_far;
  logic [TIMER_BITS-1:0] timer_kept;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  in_window;
  logic                  inc_expired;
  logic                  l_press;
  logic                  l_rel;
  logic                  dbl;

  assign l_press = !left_prev_r && left_level;
  assign l_rel   = left_prev_r && !left_level;

  assign dx       = (press_x_r > pointer_x) ? (press_x_r - pointer_x) : (pointer_x - press_x_r);
  assign dy       = (press_y_r > pointer_y) ? (press_y_r - pointer_y) : (pointer_y - press_y_r);
  assign dist_sum = DIST_W'(dx) + DIST_W'(dy);
  assign too_far  = DCMP_W'(dist_sum) > DCMP_W'(cfg.dist_limit);

  assign timer_kept  = (l_press && too_far) ? '0 : timer_r;
  assign timer_inc   = timer_kept + TIMER_BITS'(1);
  assign in_window   = (timer_kept != '0) && (TCMP_W'(timer_kept) < TCMP_W'(cfg.max_ticks));
  assign inc_expired = TCMP_W'(timer_inc) >= TCMP_W'(cfg.max_ticks);
  assign dbl         = l_rel && in_window;

  always_comb begin
    timer_nxt = timer_kept;
    if (l_rel) begin
      timer_nxt = in_window ? '0 : TIMER_BITS'(1);
    end else if (timer_kept != '0) begin
      timer_nxt = inc_expired ? '0 : timer_inc;
    end
  end

  assign left_prev_nxt  = left_level;
  assign right_prev_nxt = right_level;
  assign press_x_nxt    = l_press ? pointer_x : press_x_r;
  assign press_y_nxt    = l_press ? pointer_y : press_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_prev_r  <= 1'b0;
      right_prev_r <= 1'b0;
      press_x_r    <= '0;
      press_y_r    <= '0;
      timer_r      <= '0;
    end else if (step) begin
      left_prev_r  <= left_prev_nxt;
      right_prev_r <= right_prev_nxt;
      press_x_r    <= press_x_nxt;
      press_y_r    <= press_y_nxt;
      timer_r      <= timer_nxt;
    end
  end

  assign flags.left_was_down     = left_prev_r;
  assign flags.right_was_down    = right_prev_r;
  assign flags.left_pressed      = l_press;
  assign flags.right_pressed     = !right_prev_r && right_level;
  assign flags.left_released     = l_rel;
  assign flags.right_released    = right_prev_r && !right_level;
  assign flags.left_double_click = dbl;

endmodule

>>> rtl/mouse_button_click_qualifier_core.sv
// ----------------------------------------------------------------------------
// mouse_button_click_qualifier_core
// per-poll button edge and left double-click qualifier
// ----------------------------------------------------------------------------
// one result per poll, one poll per cycle sustained while the output is not
// stalled; each poll passes the input register and then the result register
// around the edge, distance and timer logic; a stalled output holds both
// stages, the input side keeps accepting while the input stage is free
module mouse_button_click_qualifier_core #(
  parameter int COORD_BITS = 10,
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pointer_x, pointer_y, left_level, right_level, zero pad
  input  logic [((2*COORD_BITS+2+7)/8)*8-1:0] in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_x, out_y, left_down, right_down, left_was_down, right_was_down,
  // left_pressed, right_pressed, left_released, right_released,
  // left_double_click, zero pad
  output logic [((2*COORD_BITS+9+7)/8)*8-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbcq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbcq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int OUT_W = ((2*COORD_BITS+9+7)/8)*8;

  mbcq_pkg::cfg_t   cfg;
  mbcq_pkg::flags_t flags;

  logic                  in_valid_r;
  logic [COORD_BITS-1:0] x_r;
  logic [COORD_BITS-1:0] y_r;
  logic                  lb_r;
  logic                  rb_r;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] ox_r;
  logic [COORD_BITS-1:0] oy_r;
  logic                  ol_r;
  logic                  or_r;
  mbcq_pkg::flags_t      oflags_r;

  logic advance;
  logic step;

  assign advance   = !out_valid_r || out_tready;
  assign step      = advance && in_valid_r;
  assign in_tready = !in_valid_r || advance;

  mbcq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbcq_track #(
    .COORD_BITS (COORD_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .pointer_x   (x_r),
    .pointer_y   (y_r),
    .left_level  (lb_r),
    .right_level (rb_r),
    .cfg         (cfg),
    .flags       (flags)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r  <= in_tdata[COORD_BITS-1:0];
      y_r  <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      lb_r <= in_tdata[2*COORD_BITS];
      rb_r <= in_tdata[2*COORD_BITS+1];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ox_r     <= x_r;
      oy_r     <= y_r;
      ol_r     <= lb_r;
      or_r     <= rb_r;
      oflags_r <= flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({oflags_r.left_double_click, oflags_r.right_released,
                              oflags_r.left_released, oflags_r.right_pressed,
                              oflags_r.left_pressed, oflags_r.right_was_down,
                              oflags_r.left_was_down, or_r, ol_r, oy_r, ox_r});

  a_dbl_on_release : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!oflags_r.left_double_click || oflags_r.left_released))
    else $error("double click without left release");

  a_press_edge : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (oflags_r.left_pressed == (ol_r && !oflags_r.left_was_down)))
    else $error("left press flag disagrees with levels");

  a_no_press_and_release : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(oflags_r.right_pressed && oflags_r.right_released))
    else $error("right press and release in one poll");

  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !in_valid_r) |=> !out_tvalid)
    else $error("result repeated after drain");

  a_hold_state : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r && $stable(x_r) && $stable(lb_r))
    else $error("input stage lost while output stalled");

endmodule
